// File: hw/rtl/bmtm_pkg.sv
`timescale 1ns / 1ps

package bmtm_pkg;

    // Store geometry
    localparam int STORE_WORDS = 512;
    localparam int WORD_BITS   = 8;

    // Fixed field widths
    localparam int CMD_W      = 3;
    localparam int POS_W      = 12;
    localparam int MASK_W     = 2;
    localparam int VAL_W      = 2;
    localparam int PAIR_IDX_W = 11;

    localparam int PAIRS_PER_WORD = WORD_BITS / 2;

    // Constant division by reciprocal: exact for numerators below 2**POS_W
    // and divisors up to 64.
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_BIT   = (2 ** RECIP_SHIFT + WORD_BITS - 1) / WORD_BITS;
    localparam int RECIP_PAIR  = (2 ** RECIP_SHIFT + PAIRS_PER_WORD - 1) / PAIRS_PER_WORD;
    localparam int RECIP_MAX   = (RECIP_PAIR > RECIP_BIT) ? RECIP_PAIR : RECIP_BIT;
    localparam int RECIP_W     = $clog2(RECIP_MAX + 1);
    localparam int PROD_W      = POS_W + RECIP_W;

    localparam int QUOT_BIT_MAX  = (2 ** POS_W - 1) / WORD_BITS;
    localparam int QUOT_PAIR_MAX = (2 ** PAIR_IDX_W - 1) / PAIRS_PER_WORD;
    localparam int QUOT_MAX      = (QUOT_PAIR_MAX > QUOT_BIT_MAX) ? QUOT_PAIR_MAX : QUOT_BIT_MAX;
    localparam int QUOT_W        = $clog2(QUOT_MAX + 1);

    localparam int ADDR_W = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int SH_W   = $clog2(WORD_BITS);

    typedef enum logic [CMD_W-1:0] {
        CMD_TEST             = 3'd0,
        CMD_TEST_SET         = 3'd1,
        CMD_TEST_CLEAR       = 3'd2,
        CMD_PAIR_FETCH       = 3'd3,
        CMD_PAIR_FETCH_SET   = 3'd4,
        CMD_PAIR_FETCH_CLEAR = 3'd5
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MODIFY
    } state_t;

    typedef struct packed {
        logic load;
        logic clear_wr;
        logic rd_en;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_full;
    } dp_status_t;

endpackage

// File: hw/rtl/bmtm_ctrl.sv
`timescale 1ns / 1ps

module bmtm_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   m_ready,
    input  bmtm_pkg::dp_status_t   status,
    output logic                   s_ready,
    output bmtm_pkg::ctrl_cmd_t    cmd
);
    import bmtm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY: begin
                if (!status.out_full || m_ready) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_READ: begin
                cmd.rd_en = 1'b1;
            end
            ST_MODIFY: begin
                // wait here while the previous word is still unclaimed
                cmd.commit = !status.out_full || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: hw/rtl/bmtm_datapath.sv
`timescale 1ns / 1ps

module bmtm_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bmtm_pkg::ctrl_cmd_t           cmd,
    input  logic [bmtm_pkg::CMD_W-1:0]    s_cmd,
    input  logic [bmtm_pkg::POS_W-1:0]    s_position,
    input  logic [bmtm_pkg::MASK_W-1:0]   s_pair_mask,
    input  logic                          m_ready,
    output bmtm_pkg::dp_status_t          status,
    output logic                          m_valid,
    output logic [bmtm_pkg::VAL_W-1:0]    m_old_value
);
    import bmtm_pkg::*;

    // Captured command
    logic [CMD_W-1:0]     cmd_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [MASK_W-1:0]    pmask_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    prod_next;

    // Address stage
    logic [ADDR_W-1:0]    addr_reg;
    logic [SH_W-1:0]      sh_reg;
    logic                 op_ok_reg;

    logic [WORD_BITS-1:0] rd_data_reg;
    logic [VAL_W-1:0]     old_reg;
    logic [VAL_W-1:0]     old_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [ADDR_W-1:0]    clr_cnt_reg;
    logic [ADDR_W-1:0]    clr_cnt_next;

    logic [WORD_BITS-1:0] mem [STORE_WORDS];

    logic                 in_is_pair;
    logic [POS_W-1:0]     in_numer;
    logic [RECIP_W-1:0]   in_recip;

    logic                 is_pair;
    logic [POS_W-1:0]     numer;
    logic [QUOT_W-1:0]    quot;
    logic [POS_W-1:0]     quot_times_d;
    logic [SH_W-1:0]      rem;
    logic [SH_W-1:0]      sh;
    logic                 in_range;

    logic [WORD_BITS-1:0] shifted;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] pm_word;
    logic [WORD_BITS-1:0] new_word;
    logic [VAL_W-1:0]     res;

    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;

    // Word index by reciprocal multiply, taken at accept
    always_comb begin
        in_is_pair = (s_cmd >= CMD_PAIR_FETCH);
        in_numer   = in_is_pair ? {1'b0, s_position[PAIR_IDX_W-1:0]} : s_position;
        in_recip   = in_is_pair ? RECIP_W'(RECIP_PAIR) : RECIP_W'(RECIP_BIT);
        prod_next  = PROD_W'(in_numer) * PROD_W'(in_recip);
    end

    // Quotient, remainder and range check
    always_comb begin
        is_pair      = (cmd_reg >= CMD_PAIR_FETCH);
        numer        = is_pair ? {1'b0, pos_reg[PAIR_IDX_W-1:0]} : pos_reg;
        quot         = QUOT_W'(prod_reg >> RECIP_SHIFT);
        quot_times_d = is_pair ? POS_W'(quot * PAIRS_PER_WORD) : POS_W'(quot * WORD_BITS);
        rem          = SH_W'(numer - quot_times_d);
        sh           = is_pair ? SH_W'({rem, 1'b0}) : rem;
        in_range     = (32'(quot) < STORE_WORDS);
    end

    // Read-modify-write of the fetched word
    always_comb begin
        shifted  = rd_data_reg >> sh_reg;
        bit_mask = WORD_BITS'(1) << sh_reg;
        pm_word  = WORD_BITS'(pmask_reg) << sh_reg;
        new_word = rd_data_reg;
        res      = '0;
        case (cmd_reg)
            CMD_TEST: begin
                res = {1'b0, shifted[0]};
            end
            CMD_TEST_SET: begin
                res      = {1'b0, shifted[0]};
                new_word = rd_data_reg | bit_mask;
            end
            CMD_TEST_CLEAR: begin
                res      = {1'b0, shifted[0]};
                new_word = rd_data_reg & ~bit_mask;
            end
            CMD_PAIR_FETCH: begin
                res = shifted[1:0];
            end
            CMD_PAIR_FETCH_SET: begin
                res      = shifted[1:0] & pmask_reg;
                new_word = rd_data_reg | pm_word;
            end
            CMD_PAIR_FETCH_CLEAR: begin
                res      = shifted[1:0] & pmask_reg;
                new_word = rd_data_reg & ~pm_word;
            end
            default: begin
                res = '0;
            end
        endcase
        if (!op_ok_reg) res = '0;
    end

    always_comb begin
        we    = cmd.clear_wr || (cmd.commit && op_ok_reg);
        waddr = cmd.clear_wr ? clr_cnt_reg : addr_reg;
        wdata = cmd.clear_wr ? '0 : new_word;
    end

    always_comb begin
        clr_cnt_next   = cmd.clear_wr ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
        old_next       = cmd.commit ? res : old_reg;
        out_valid_next = cmd.commit ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        old_reg <= old_next;
        if (cmd.load) begin
            cmd_reg   <= s_cmd;
            pos_reg   <= s_position;
            pmask_reg <= s_pair_mask;
            prod_reg  <= prod_next;
        end
        if (cmd.rd_en) begin
            addr_reg  <= ADDR_W'(quot);
            sh_reg    <= sh;
            op_ok_reg <= in_range && (cmd_reg <= CMD_PAIR_FETCH_CLEAR);
        end
    end

    // Store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (cmd.rd_en) rd_data_reg <= mem[ADDR_W'(quot)];
    end

    assign status.clear_last = (clr_cnt_reg == ADDR_W'(STORE_WORDS - 1));
    assign status.out_full   = out_valid_reg;
    assign m_valid           = out_valid_reg;
    assign m_old_value       = old_reg;

endmodule

// File: hw/rtl/bitmap_test_and_modify.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Word
// s_       in   s_valid/s_ready    s_cmd[2:0], s_position[11:0], s_pair_mask[1:0]
// m_       out  m_valid/m_ready    m_old_value[1:0]
//
// Each command goes from accept to result word through accept (index
// multiply), store read, and modify and write back, in that order.
// After reset a clearing pass zeroes all STORE_WORDS (512) words of the
// store, with s_ready low. The result register lets the next command be
// accepted while a result waits; a command stalls in its write-back cycle
// only if the previous result is still unclaimed.
module bitmap_test_and_modify (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bmtm_pkg::CMD_W-1:0]    s_cmd,
    input  logic [bmtm_pkg::POS_W-1:0]    s_position,
    input  logic [bmtm_pkg::MASK_W-1:0]   s_pair_mask,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bmtm_pkg::VAL_W-1:0]    m_old_value
);
    import bmtm_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer: clear pass, accept, read, write back
    bmtm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .m_ready (m_ready),
        .status  (status),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    // Index math, store and result register
    bmtm_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_cmd       (s_cmd),
        .s_position  (s_position),
        .s_pair_mask (s_pair_mask),
        .m_ready     (m_ready),
        .status      (status),
        .m_valid     (m_valid),
        .m_old_value (m_old_value)
    );

endmodule

// File: hw/rtl/bmtm_checker.sv
`timescale 1ns / 1ps

module bmtm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [bmtm_pkg::VAL_W-1:0]    m_old_value
);
    import bmtm_pkg::*;

    // Reset starts the clear pass: nothing taken, nothing offered
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("ports active right after reset");

    // One command in flight: busy for the read and write-back cycles
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("new word accepted while a command is in flight");

    // A stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_old_value))
        else $error("result changed while stalled");

endmodule

bind bitmap_test_and_modify bmtm_checker u_checker (.*);
